// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

	// screen geometry defaults
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// field widths
	localparam int OP_W     = 3;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int POS_X_W  = 7;
	localparam int POS_Y_W  = 5;
	localparam int OFFSET_W = 11;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	// character codes and fixed values
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;
	localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0F;
	localparam int                JUMP_COLUMN    = 75;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 3'd0,
		OP_MOVE  = 3'd1,
		OP_CLEAR = 3'd2,
		OP_COL75 = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_COPY,
		ST_BLANK,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch_item;
		logic exec;
		logic read_cell;
		logic cnt_clr;
		logic cnt_inc;
		logic fill;
		logic fill_reset_attr;
		logic scroll_rd;
		logic copy_wr;
		logic load_out;
		logic out_next;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_scroll;
		logic op_clear;
		logic op_read;
		logic cnt_zero;
		logic cnt_copy_end;
		logic cnt_last;
	} status_t;

endpackage

// ===== rtl/core/tcw_cmd_if.sv =====
interface tcw_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::OP_W-1:0]     operation;
	logic [tcw_pkg::CHAR_W-1:0]   char_code;
	logic [tcw_pkg::POS_X_W-1:0]  pos_x;
	logic [tcw_pkg::POS_Y_W-1:0]  pos_y;

	modport source (output valid, output operation, output char_code, output pos_x,
		output pos_y, input ready);
	modport sink (input valid, input operation, input char_code, input pos_x,
		input pos_y, output ready);
endinterface

// ===== rtl/core/tcw_res_if.sv =====
interface tcw_res_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::POS_X_W-1:0]   cursor_x;
	logic [tcw_pkg::POS_Y_W-1:0]   cursor_y;
	logic [tcw_pkg::OFFSET_W-1:0]  cursor_offset;
	logic [tcw_pkg::CHAR_W-1:0]    cell_char;
	logic [tcw_pkg::ATTR_W-1:0]    cell_attr;

	modport source (output valid, output cursor_x, output cursor_y, output cursor_offset,
		output cell_char, output cell_attr, input ready);
	modport sink (input valid, input cursor_x, input cursor_y, input cursor_offset,
		input cell_char, input cell_attr, output ready);
endinterface

// ===== rtl/core/tcw_ctrl.sv =====
module tcw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  tcw_pkg::status_t status,
	output tcw_pkg::cmd_t    cmd
);

	tcw_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;
	logic            exec_fast;

	assign out_free  = !out_valid_q || out_ready;
	assign exec_fast = !status.need_scroll && !status.op_clear && !status.op_read && out_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (status.cnt_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (in_valid) state_d = tcw_pkg::ST_EXEC;
			end
			tcw_pkg::ST_EXEC: begin
				priority if (status.need_scroll) state_d = tcw_pkg::ST_COPY;
				else if (status.op_clear) state_d = tcw_pkg::ST_FILL;
				else if (exec_fast) state_d = tcw_pkg::ST_IDLE;
				else state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_FILL: begin
				if (status.cnt_last) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_COPY: begin
				if (status.cnt_copy_end) state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				if (status.cnt_last) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE: begin
				if (out_free) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				cmd.fill            = 1'b1;
				cmd.fill_reset_attr = 1'b1;
				cmd.cnt_inc         = !status.cnt_last;
			end
			tcw_pkg::ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.latch_item = in_valid;
			end
			tcw_pkg::ST_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.cnt_clr   = 1'b1;
				cmd.read_cell = status.op_read;
				cmd.load_out  = exec_fast;
				cmd.out_next  = 1'b1;
			end
			tcw_pkg::ST_FILL, tcw_pkg::ST_BLANK: begin
				cmd.fill    = 1'b1;
				cmd.cnt_inc = !status.cnt_last;
			end
			tcw_pkg::ST_COPY: begin
				cmd.scroll_rd = !status.cnt_copy_end;
				cmd.copy_wr   = !status.cnt_zero;
				cmd.cnt_inc   = !status.cnt_copy_end;
			end
			tcw_pkg::ST_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/tcw_datapath.sv =====
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcw_pkg::cmd_t                  cmd,
	output tcw_pkg::status_t               status,
	input  logic [tcw_pkg::OP_W-1:0]       operation,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcw_pkg::POS_X_W-1:0]    pos_x,
	input  logic [tcw_pkg::POS_Y_W-1:0]    pos_y,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]     cfg_wdata,
	output logic [tcw_pkg::POS_X_W-1:0]    cursor_x,
	output logic [tcw_pkg::POS_Y_W-1:0]    cursor_y,
	output logic [tcw_pkg::OFFSET_W-1:0]   cursor_offset,
	output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
	output logic [tcw_pkg::ATTR_W-1:0]     cell_attr
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam logic [CW-1:0] COL_MAX = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_JUMP =
		(tcw_pkg::JUMP_COLUMN >= COLUMNS) ? COL_MAX : CW'(tcw_pkg::JUMP_COLUMN);

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
		return AW'(32'(r) * COLUMNS + 32'(c));
	endfunction

	// item and cursor state
	tcw_pkg::op_t                 op_q;
	logic [tcw_pkg::CHAR_W-1:0]   ch_q;
	logic [tcw_pkg::POS_X_W-1:0]  px_q;
	logic [tcw_pkg::POS_Y_W-1:0]  py_q;
	logic [tcw_pkg::ATTR_W-1:0]   attr_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [AW-1:0]                cnt_q;

	// screen store
	logic [tcw_pkg::CELL_W-1:0]   mem [CELLS];
	logic [tcw_pkg::CELL_W-1:0]   rdata_q;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;

	// next cursor and put write
	logic [CW-1:0]                nx_col;
	logic [RW-1:0]                nx_row;
	logic [CW-1:0]                clamp_col;
	logic [RW-1:0]                clamp_row;
	logic                         row_inc;
	logic                         scroll;
	logic                         put_we;
	logic [CW-1:0]                put_col;
	logic [RW-1:0]                put_row;
	logic [tcw_pkg::CHAR_W-1:0]   put_char;
	logic [CW-1:0]                res_col;
	logic [RW-1:0]                res_row;

	// result register
	logic [tcw_pkg::POS_X_W-1:0]  res_x_q;
	logic [tcw_pkg::POS_Y_W-1:0]  res_y_q;
	logic [tcw_pkg::OFFSET_W-1:0] res_off_q;
	logic [tcw_pkg::CHAR_W-1:0]   res_char_q;
	logic [tcw_pkg::ATTR_W-1:0]   res_attr_q;

	assign clamp_col = (32'(px_q) >= COLUMNS) ? COL_MAX : CW'(px_q);
	assign clamp_row = (32'(py_q) >= ROWS) ? ROW_MAX : RW'(py_q);

	always_comb begin
		nx_col   = col_q;
		nx_row   = row_q;
		row_inc  = 1'b0;
		scroll   = 1'b0;
		put_we   = 1'b0;
		put_col  = col_q;
		put_row  = row_q;
		put_char = ch_q;
		unique case (op_q)
			tcw_pkg::OP_PUT: begin
				priority if (ch_q == tcw_pkg::CHAR_NEWLINE) begin
					nx_col  = '0;
					row_inc = 1'b1;
				end else if (ch_q == tcw_pkg::CHAR_BACKSPACE) begin
					put_char = tcw_pkg::CHAR_SPACE;
					priority if (col_q != '0) begin
						nx_col  = col_q - CW'(1);
						put_col = col_q - CW'(1);
						put_we  = 1'b1;
					end else if (row_q != '0) begin
						nx_col  = COL_MAX;
						nx_row  = row_q - RW'(1);
						put_col = COL_MAX;
						put_row = row_q - RW'(1);
						put_we  = 1'b1;
					end else begin
						nx_col = col_q;
					end
				end else begin
					put_we = 1'b1;
					if (col_q == COL_MAX) begin
						nx_col  = '0;
						row_inc = 1'b1;
					end else begin
						nx_col = col_q + CW'(1);
					end
				end
				// off the bottom row: scroll, cursor stays on the last row
				if (row_inc) begin
					if (row_q == ROW_MAX) begin
						scroll = 1'b1;
						nx_row = ROW_MAX;
					end else begin
						nx_row = row_q + RW'(1);
					end
				end
			end
			tcw_pkg::OP_MOVE: begin
				nx_col = clamp_col;
				nx_row = clamp_row;
			end
			tcw_pkg::OP_CLEAR: begin
				nx_col = '0;
				nx_row = '0;
			end
			tcw_pkg::OP_COL75: begin
				nx_col = COL_JUMP;
			end
			default: begin
				nx_col = col_q;
			end
		endcase
	end

	assign status.need_scroll  = scroll;
	assign status.op_clear     = (op_q == tcw_pkg::OP_CLEAR);
	assign status.op_read      = (op_q == tcw_pkg::OP_READ);
	assign status.cnt_zero     = (cnt_q == '0);
	assign status.cnt_copy_end = (32'(cnt_q) == CELLS - COLUMNS);
	assign status.cnt_last     = (32'(cnt_q) == CELLS - 1);

	// store port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = {attr_q, tcw_pkg::CHAR_SPACE};
		priority if (cmd.fill) begin
			mem_we    = 1'b1;
			mem_wdata = {(cmd.fill_reset_attr ? tcw_pkg::ATTR_RESET : attr_q),
				tcw_pkg::CHAR_SPACE};
		end else if (cmd.copy_wr) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q - AW'(1);
			mem_wdata = rdata_q;
		end else if (cmd.exec && put_we) begin
			mem_we    = 1'b1;
			mem_waddr = addr_of(put_row, put_col);
			mem_wdata = {attr_q, put_char};
		end else begin
			mem_we = 1'b0;
		end
	end

	assign mem_re    = cmd.read_cell || cmd.scroll_rd;
	assign mem_raddr = cmd.scroll_rd ? AW'(32'(cnt_q) + COLUMNS) : addr_of(clamp_row, clamp_col);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			op_q <= tcw_pkg::op_t'(operation);
			ch_q <= char_code;
			px_q <= pos_x;
			py_q <= pos_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
			col_q  <= '0;
			row_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				col_q <= nx_col;
				row_q <= nx_row;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	assign res_col = cmd.out_next ? nx_col : col_q;
	assign res_row = cmd.out_next ? nx_row : row_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_x_q   <= tcw_pkg::POS_X_W'(res_col);
			res_y_q   <= tcw_pkg::POS_Y_W'(res_row);
			res_off_q <= tcw_pkg::OFFSET_W'(32'(res_row) * COLUMNS + 32'(res_col));
			if (op_q == tcw_pkg::OP_READ) begin
				res_char_q <= rdata_q[tcw_pkg::CHAR_W-1:0];
				res_attr_q <= rdata_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
			end else begin
				res_char_q <= '0;
				res_attr_q <= '0;
			end
		end
	end

	assign cursor_x      = res_x_q;
	assign cursor_y      = res_y_q;
	assign cursor_offset = res_off_q;
	assign cell_char     = res_char_q;
	assign cell_attr     = res_attr_q;

endmodule

// ===== rtl/core/text_console_writer.sv =====
// flow: idle takes an item, execute runs it; put, move, column jump and unused codes load the
//   result there if the output is free, else in done; read cell fetches the cell, then done;
//   clear walks the store in fill, a scrolling put in copy (rows up) and blank (last row), then
//   done; the next item is taken only once the result of the last is loaded
// reset: asynchronous, active low; afterwards a clearing pass fills the store with blanks
//   (attribute 0x0F) and no item is taken, register writes still are
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tcw_cmd_if.sink                     cmd,
	tcw_res_if.source                   res,
	input  logic                        cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata
);

	// command and status between the sequencer and the datapath
	tcw_pkg::cmd_t    ctl_cmd;
	tcw_pkg::status_t dp_status;

	// sequencer: reset clearing pass, item execution, clear and scroll sweeps,
	// and the result valid flag
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (dp_status),
		.cmd       (ctl_cmd)
	);

	// datapath: screen store, cursor, attribute register and result register
	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.status        (dp_status),
		.operation     (cmd.operation),
		.char_code     (cmd.char_code),
		.pos_x         (cmd.pos_x),
		.pos_y         (cmd.pos_y),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cursor_x      (res.cursor_x),
		.cursor_y      (res.cursor_y),
		.cursor_offset (res.cursor_offset),
		.cell_char     (res.cell_char),
		.cell_attr     (res.cell_attr)
	);

	// a pending result is never overwritten
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.load_out |-> (!res.valid || res.ready))
		else $error("result register loaded while a result waits");

	// no input transfer while a sweep owns the store
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |-> !(ctl_cmd.fill || ctl_cmd.copy_wr || ctl_cmd.scroll_rd))
		else $error("input transfer during a store sweep");

	// an accepted item is executed in the following cycle, one at a time
	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (ctl_cmd.exec && !cmd.ready))
		else $error("accepted item not executed next cycle");

endmodule
